[design/svf_pkg.sv]
// Package for the state variable filter: state codes, register indexes,
// coefficient limits and the saturation helpers. No dependencies.
`default_nettype none

package svf_pkg;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_FREQ = 2'd1;
    localparam logic [1:0] REG_DAMP = 2'd2;
    localparam logic [1:0] REG_WET  = 2'd3;

    // Response selection codes.
    localparam logic [1:0] MODE_LOW   = 2'd0;
    localparam logic [1:0] MODE_HIGH  = 2'd1;
    localparam logic [1:0] MODE_BAND  = 2'd2;
    localparam logic [1:0] MODE_NOTCH = 2'd3;

    // Reset values and limits of the coefficients.
    localparam logic [1:0]  MODE_RESET = MODE_LOW;
    localparam logic [14:0] FREQ_RESET = 15'd2143;
    localparam logic [15:0] DAMP_RESET = 16'd5793;
    localparam logic [15:0] WET_RESET  = 16'd32768;
    localparam logic [15:0] WET_ONE    = 16'd32768;
    localparam logic [15:0] DAMP_MAX   = 16'd40960;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_FB   = 9'b000000010,
        ST_LOW  = 9'b000000100,
        ST_HIGH = 9'b000001000,
        ST_FH   = 9'b000010000,
        ST_BAND = 9'b000100000,
        ST_WET  = 9'b001000000,
        ST_DRY  = 9'b010000000,
        ST_MIX  = 9'b100000000
    } t_state;

    // Clamp a 40-bit intermediate to the signed 32-bit integrator range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a 26-bit rounded mix to the signed 16-bit sample range.
    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        logic signed [15:0] r;
        if (v > 26'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -26'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/state_variable_filter.sv]
// Top level of the state variable filter: stream ports, register port,
// integrators and the shared multiplier sequencer. Depends on svf_pkg.
`default_nettype none

// Chamberlin state variable filter for signed Q1.15 audio samples. Each
// accepted item updates the lowpass and bandpass integrators (Q8.24, saturated
// to 32 bits) and produces one output item: a dry/wet mix of the input and the
// response chosen by filter_mode (lowpass, highpass, bandpass or notch),
// rounded half up and saturated to 16 bits; tlast is passed through unchanged.
// One signed 32 by 17 bit multiplier is shared by all five products of a
// sample, so an item runs through eight sequencer steps after the idle state
// that takes it before the next can be taken. s_axis_tready is high only
// while the sequencer is idle. The result sits in an output register, so the
// next item is taken while it waits; the sequencer only stalls in its last
// step if the previous result is still held. Registers (APB, byte address 4 *
// index): 0 filter_mode, 1 freq_coeff (Q1.14), 2 damping_coeff (Q4.12, values
// above 10.0 act as 10.0), 3 wet_mix (Q1.15, values above 1.0 act as 1.0).
// Reads return the value written. Registers are to be written only while no
// item is in flight.
module state_variable_filter
    import svf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  wire logic        s_axis_tlast,   // block_end
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample_out
    output logic             m_axis_tlast,   // block_end_out
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers.
    logic [1:0]  r_mode;
    logic [14:0] r_freq;
    logic [15:0] r_damp;
    logic [15:0] r_wet;

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic signed [15:0] r_x;
    logic               r_last;
    logic signed [31:0] r_low, r_band, r_high;
    logic signed [48:0] r_prod, r_acc;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic               r_out_last;

    logic               w_cfg_wr;
    logic               w_in_acc;
    logic               w_out_free;
    logic [15:0]        w_damp_sat, w_wet_sat, w_dry;
    logic signed [24:0] w_xs;
    logic signed [31:0] w_mul_a;
    logic [15:0]        w_mul_b;
    logic signed [48:0] w_prod;
    logic signed [39:0] w_rnd14, w_rnd12;
    logic signed [31:0] w_low_new, w_high_new, w_band_new, w_sel;
    logic signed [48:0] w_mix;
    logic signed [15:0] w_y;

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; pready is tied.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_freq <= FREQ_RESET;
            r_damp <= DAMP_RESET;
            r_wet  <= WET_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_MODE: r_mode <= pwdata[1:0];
                REG_FREQ: r_freq <= pwdata[14:0];
                REG_DAMP: r_damp <= pwdata[15:0];
                REG_WET:  r_wet  <= pwdata[15:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE: prdata = {30'd0, r_mode};
            REG_FREQ: prdata = {17'd0, r_freq};
            REG_DAMP: prdata = {16'd0, r_damp};
            REG_WET:  prdata = {16'd0, r_wet};
            default:  prdata = 32'd0;
        endcase
    end

    // Out-of-range coefficients are clamped where they are used.
    assign w_damp_sat = (r_damp > DAMP_MAX) ? DAMP_MAX : r_damp;
    assign w_wet_sat  = (r_wet > WET_ONE) ? WET_ONE : r_wet;
    assign w_dry      = WET_ONE - w_wet_sat;

    // The sample on the integrator scale of 2^24.
    assign w_xs = $signed({r_x, 9'd0});

    // ------------------------------------------------------------------
    // Shared multiplier. The sequencer state picks the operands; the
    // product is always registered before it is used.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_state)
            ST_FB: begin
                w_mul_a = r_band;
                w_mul_b = {1'b0, r_freq};
            end
            ST_LOW: begin
                w_mul_a = r_band;
                w_mul_b = w_damp_sat;
            end
            ST_FH: begin
                w_mul_a = r_high;
                w_mul_b = {1'b0, r_freq};
            end
            ST_WET: begin
                w_mul_a = w_sel;
                w_mul_b = w_wet_sat;
            end
            ST_DRY: begin
                w_mul_a = 32'(w_xs);
                w_mul_b = w_dry;
            end
            default: begin
                w_mul_a = 32'sd0;
                w_mul_b = 16'd0;
            end
        endcase
    end

    assign w_prod = 49'(w_mul_a) * 49'($signed({1'b0, w_mul_b}));

    // Rounded (half up) products; the values stay well inside 40 bits.
    assign w_rnd14 = 40'((r_prod + 49'sd8192) >>> 14);
    assign w_rnd12 = 40'((r_prod + 49'sd2048) >>> 12);

    assign w_low_new  = sat32(40'(r_low) + w_rnd14);
    assign w_high_new = sat32(40'(w_xs) - 40'(r_low) - w_rnd12);
    assign w_band_new = sat32(40'(r_band) + w_rnd14);

    // Response selection; notch is highpass plus lowpass, saturated.
    always_comb begin
        case (r_mode)
            MODE_LOW:   w_sel = r_low;
            MODE_HIGH:  w_sel = r_high;
            MODE_BAND:  w_sel = r_band;
            MODE_NOTCH: w_sel = sat32(40'(r_high) + 40'(r_low));
            default:    w_sel = r_low;
        endcase
    end

    // Final mix: wet product in r_acc, dry product in r_prod, scale 2^39.
    assign w_mix = r_acc + r_prod;
    assign w_y   = sat16(26'((w_mix + 49'sd8388608) >>> 24));

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = w_in_acc ? ST_FB : ST_IDLE;
            ST_FB:   n_state = ST_LOW;
            ST_LOW:  n_state = ST_HIGH;
            ST_HIGH: n_state = ST_FH;
            ST_FH:   n_state = ST_BAND;
            ST_BAND: n_state = ST_WET;
            ST_WET:  n_state = ST_DRY;
            ST_DRY:  n_state = ST_MIX;
            ST_MIX:  n_state = w_out_free ? ST_IDLE : ST_MIX;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= 32'sd0;
            r_band  <= 32'sd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOW) begin
                r_low <= w_low_new;
            end
            if (r_state == ST_BAND) begin
                r_band <= w_band_new;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x    <= $signed(s_axis_tdata);
            r_last <= s_axis_tlast;
        end
        if (r_state == ST_HIGH) begin
            r_high <= w_high_new;
        end
        if (r_state == ST_DRY) begin
            r_acc <= r_prod;
        end
        if (r_state != ST_MIX) begin
            r_prod <= w_prod;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_MIX && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MIX && w_out_free) begin
            r_out_data <= w_y;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[design/svf_checker.sv]
// Port-level checker for the state variable filter and its bind statement.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module svf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A held output item keeps its payload until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output item changed while stalled");

    // Taking an item starts the sequencer, which is busy the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // A new result only appears at the end of a busy sequence.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in flight");

    // Reset empties the output and leaves the block ready for an item.
    assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("reset did not clear the stream state");

endmodule

bind state_variable_filter svf_checker u_svf_checker (.*);

`default_nettype wire
